// ===== design/sobel_gradient_x_stream_core_assert.svh =====
// Assertion helpers used by the checker file.
`ifndef SOBEL_GRADIENT_X_STREAM_CORE_ASSERT_SVH
`define SOBEL_GRADIENT_X_STREAM_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SGX_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SGX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/sgx_pkg.sv =====
`default_nettype none

package sgx_pkg;

    // Fixed field widths of the result beat and the side register
    localparam int COORD_W     = 10;
    localparam int GRAD_W      = 11;
    localparam int SIDE_W      = 11;
    localparam int OUT_TDATA_W = 32;

    // Defaults for the top-level parameters and the reset value of the side
    localparam int MAX_SIDE_DEF   = 1024;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int SIDE_RESET     = 512;

    // Result queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_W-1:0]     coord_t;
    typedef logic [GRAD_W-1:0]      grad_t;
    typedef logic [OUT_TDATA_W-1:0] out_tdata_t;

    // Position of a pixel within the frame
    typedef struct packed {
        logic row_first;
        logic row_interior;
        logic row_last;
        logic col_first;
        logic col_second;
        logic col_inner;
        logic col_last;
    } flags_t;

    typedef struct packed {
        coord_t row;
        coord_t col;
        grad_t  grad;
        logic   run_last;
        logic   frame_last;
    } result_t;

    // Up to two results produced by one pixel; v1 implies v0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } emit_t;

    function automatic result_t mk_result(coord_t row, coord_t col, grad_t grad);
        result_t r;
        r.row        = row;
        r.col        = col;
        r.grad       = grad;
        r.run_last   = 1'b0;
        r.frame_last = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/sobel_gradient_x_stream_core.sv =====
// Path: a pixel is registered in the input stage, and its results in the result queue.
// Throughput: one pixel per cycle while the queue has room for two results; the output
//   port carries one result per cycle; right border and bottom row pixels release two.
// Reset: rst_n (async, active low) clears position counters, window, result queue and
//   sets the side to 512. The two line stores are not cleared and need no clearing pass.
`default_nettype none

module sobel_gradient_x_stream_core #(
    parameter int MAX_SIDE    = sgx_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS  = sgx_pkg::PIXEL_BITS_DEF,
    localparam int IN_TDATA_W = ((PIXEL_BITS + 7) / 8) * 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sgx_pkg::SIDE_W-1:0]      cfg_wdata,      // image_side
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]           s_axis_tdata,   // pixel
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [sgx_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // out_row, out_col, gradient
    output logic                                 m_axis_tlast,   // run_last
    output logic                                 m_axis_tuser    // frame_last
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int EW = (SW > sgx_pkg::SIDE_W) ? SW : sgx_pkg::SIDE_W;
    localparam int RESET_SIDE = (MAX_SIDE < sgx_pkg::SIDE_RESET) ? MAX_SIDE : sgx_pkg::SIDE_RESET;

    logic [CW-1:0]          last_idx_reg;
    logic [CW-1:0]          last_idx_next;
    logic [CW-1:0]          row_cnt_reg;
    logic [CW-1:0]          row_cnt_next;
    logic [CW-1:0]          col_cnt_reg;
    logic [CW-1:0]          col_cnt_next;
    logic [EW-1:0]          side_w;

    logic                   s1_valid_reg;
    logic [PIXEL_BITS-1:0]  s1_pixel_reg;
    logic [CW-1:0]          s1_row_reg;
    logic [CW-1:0]          s1_col_reg;
    sgx_pkg::flags_t        s1_flags_reg;
    sgx_pkg::flags_t        flags_next;

    logic [PIXEL_BITS-1:0]  win_reg [6];
    logic [PIXEL_BITS-1:0]  line_mid;
    logic [PIXEL_BITS-1:0]  line_top;

    logic                   accept;
    logic                   advance;
    logic                   room;
    sgx_pkg::emit_t         emit;
    sgx_pkg::result_t       out_data;

    assign advance       = s1_valid_reg & room;
    assign s_axis_tready = ~s1_valid_reg | advance;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // Clamp the written side to the supported range, keep it as last index
    always_comb
    begin
        side_w = EW'(cfg_wdata);
        if (side_w < EW'(3))
        begin
            last_idx_next = CW'(2);
        end
        else if (side_w > EW'(MAX_SIDE))
        begin
            last_idx_next = CW'(MAX_SIDE - 1);
        end
        else
        begin
            last_idx_next = CW'(side_w - EW'(1));
        end
    end

    // Raster position of the next pixel
    always_comb
    begin
        if (col_cnt_reg == last_idx_reg)
        begin
            col_cnt_next = '0;
            row_cnt_next = (row_cnt_reg == last_idx_reg) ? '0 : row_cnt_reg + CW'(1);
        end
        else
        begin
            col_cnt_next = col_cnt_reg + CW'(1);
            row_cnt_next = row_cnt_reg;
        end
    end

    // Classify the incoming pixel position
    always_comb
    begin
        flags_next.row_first    = (row_cnt_reg == '0);
        flags_next.row_interior = (row_cnt_reg > CW'(1));
        flags_next.row_last     = (row_cnt_reg == last_idx_reg);
        flags_next.col_first    = (col_cnt_reg == '0);
        flags_next.col_second   = (col_cnt_reg == CW'(1));
        flags_next.col_inner    = (col_cnt_reg > CW'(1));
        flags_next.col_last     = (col_cnt_reg == last_idx_reg);
    end

    // Side register and counters; a side write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_idx_reg <= CW'(RESET_SIDE - 1);
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
        end
        else if (cfg_we)
        begin
            last_idx_reg <= last_idx_next;
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= s_axis_tdata[PIXEL_BITS-1:0];
            s1_row_reg   <= row_cnt_reg;
            s1_col_reg   <= col_cnt_reg;
            s1_flags_reg <= flags_next;
        end
    end

    // Shift the window one column when the pixel leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= line_top;
            win_reg[4] <= line_mid;
            win_reg[5] <= s1_pixel_reg;
        end
    end

    // Line stores: read on accept, write back on advance
    sgx_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_SIDE)
    ) u_line_above (
        .clk     (clk),
        .wr_en   (advance),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .rd_data (line_mid)
    );

    sgx_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_SIDE)
    ) u_line_two_above (
        .clk     (clk),
        .wr_en   (advance),
        .wr_addr (s1_col_reg),
        .wr_data (line_mid),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .rd_data (line_top)
    );

    sgx_emit #(
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW)
    ) u_emit (
        .flags    (s1_flags_reg),
        .row      (s1_row_reg),
        .col      (s1_col_reg),
        .top      (line_top),
        .mid      (line_mid),
        .pix      (s1_pixel_reg),
        .left_top (win_reg[0]),
        .left_mid (win_reg[1]),
        .left_bot (win_reg[2]),
        .emit     (emit)
    );

    sgx_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (advance),
        .push      (emit),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    // Pack the result beat
    assign m_axis_tdata = sgx_pkg::out_tdata_t'({out_data.grad, out_data.col, out_data.row});
    assign m_axis_tlast = out_data.run_last;
    assign m_axis_tuser = out_data.frame_last;

endmodule

`default_nettype wire

// ===== design/sgx_ram.sv =====
`default_nettype none

module sgx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/sgx_emit.sv =====
`default_nettype none

module sgx_emit #(
    parameter int PIXEL_BITS = 8,
    parameter int CW         = 10
) (
    input  wire sgx_pkg::flags_t        flags,
    input  wire logic [CW-1:0]          row,
    input  wire logic [CW-1:0]          col,
    input  wire logic [PIXEL_BITS-1:0]  top,
    input  wire logic [PIXEL_BITS-1:0]  mid,
    input  wire logic [PIXEL_BITS-1:0]  pix,
    input  wire logic [PIXEL_BITS-1:0]  left_top,
    input  wire logic [PIXEL_BITS-1:0]  left_mid,
    input  wire logic [PIXEL_BITS-1:0]  left_bot,
    output sgx_pkg::emit_t              emit
);

    localparam int SUM_W = PIXEL_BITS + 2;
    localparam int WW    = (PIXEL_BITS + 3 > sgx_pkg::GRAD_W) ? PIXEL_BITS + 3 : sgx_pkg::GRAD_W;
    localparam logic signed [WW-1:0] G_MAX = WW'((1 << (sgx_pkg::GRAD_W - 1)) - 1);
    localparam logic signed [WW-1:0] G_MIN = WW'(-(1 << (sgx_pkg::GRAD_W - 1)));

    logic [SUM_W-1:0]        right_sum;
    logic [SUM_W-1:0]        left_sum;
    logic signed [WW-1:0]    diff;
    logic signed [WW-1:0]    diff_sat;
    sgx_pkg::grad_t          grad;
    sgx_pkg::coord_t         row_c;
    sgx_pkg::coord_t         row_up;
    sgx_pkg::coord_t         col_c;
    sgx_pkg::coord_t         col_left;
    sgx_pkg::coord_t         col_right;
    logic                    frame_end;

    // Column sums weighted 1-2-1, right minus left, clamp to the result range
    always_comb
    begin
        right_sum = SUM_W'(top) + (SUM_W'(mid) << 1) + SUM_W'(pix);
        left_sum  = SUM_W'(left_top) + (SUM_W'(left_mid) << 1) + SUM_W'(left_bot);
        diff      = signed'(WW'(right_sum)) - signed'(WW'(left_sum));
        if (diff > G_MAX)
        begin
            diff_sat = G_MAX;
        end
        else if (diff < G_MIN)
        begin
            diff_sat = G_MIN;
        end
        else
        begin
            diff_sat = diff;
        end
        grad = diff_sat[sgx_pkg::GRAD_W-1:0];
    end

    // Coordinates of the results this pixel can release
    assign row_c     = sgx_pkg::coord_t'(row);
    assign row_up    = sgx_pkg::coord_t'(row - CW'(1));
    assign col_c     = sgx_pkg::coord_t'(col);
    assign col_left  = sgx_pkg::coord_t'(col - CW'(1));
    assign col_right = sgx_pkg::coord_t'(col + CW'(1));
    assign frame_end = flags.row_last & flags.col_last;

    // Pick the results in emission order, then mark the last one
    always_comb
    begin
        emit    = '0;
        if (flags.row_first)
        begin
            emit.v0 = 1'b1;
            emit.r0 = sgx_pkg::mk_result('0, col_c, '0);
        end
        else if (flags.row_interior)
        begin
            if (flags.col_first)
            begin
                emit.v0 = 1'b1;
                emit.r0 = sgx_pkg::mk_result(row_up, '0, '0);
                if (flags.row_last)
                begin
                    emit.v1 = 1'b1;
                    emit.r1 = sgx_pkg::mk_result(row_c, '0, '0);
                end
            end
            else if (flags.col_second)
            begin
                if (flags.row_last)
                begin
                    emit.v0 = 1'b1;
                    emit.r0 = sgx_pkg::mk_result(row_c, sgx_pkg::coord_t'(1), '0);
                    emit.v1 = 1'b1;
                    emit.r1 = sgx_pkg::mk_result(row_c, sgx_pkg::coord_t'(2), '0);
                end
            end
            else if (flags.col_inner)
            begin
                emit.v0 = 1'b1;
                emit.r0 = sgx_pkg::mk_result(row_up, col_left, grad);
                if (flags.col_last)
                begin
                    emit.v1 = 1'b1;
                    emit.r1 = sgx_pkg::mk_result(row_up, col_c, '0);
                end
                else if (flags.row_last)
                begin
                    emit.v1 = 1'b1;
                    emit.r1 = sgx_pkg::mk_result(row_c, col_right, '0);
                end
            end
        end

        if (emit.v1)
        begin
            emit.r1.run_last   = 1'b1;
            emit.r1.frame_last = frame_end;
        end
        else if (emit.v0)
        begin
            emit.r0.run_last   = 1'b1;
            emit.r0.frame_last = frame_end;
        end
    end

endmodule

`default_nettype wire

// ===== design/sgx_out_queue.sv =====
`default_nettype none

module sgx_out_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_en,
    input  wire sgx_pkg::emit_t   push,
    output logic                  room,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sgx_pkg::result_t      out_data
);

    localparam int DEPTH = sgx_pkg::QUEUE_DEPTH;
    localparam int PW    = sgx_pkg::QPTR_W;
    localparam int CNTW  = sgx_pkg::QCNT_W;

    sgx_pkg::result_t  entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [CNTW-1:0]   cnt_reg;
    logic [CNTW-1:0]   cnt_next;
    logic              push0;
    logic              push1;
    logic              pop;
    logic [1:0]        push_n;

    assign push0     = push_en & push.v0;
    assign push1     = push_en & push.v1;
    assign push_n    = {1'b0, push0} + {1'b0, push1};
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid & out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    // Room for a full pair of results
    assign room = (cnt_reg <= CNTW'(DEPTH - 2));

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_n);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        cnt_next    = cnt_reg + CNTW'(push_n) - CNTW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store up to two results per cycle
    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push1)
        begin
            entry_reg[wr_ptr_reg + PW'(1)] <= push.r1;
        end
    end

endmodule

`default_nettype wire

// ===== design/sgx_checker.sv =====
`default_nettype none
`include "sobel_gradient_x_stream_core_assert.svh"

module sgx_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [sgx_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                          m_axis_tlast,
    input  wire logic                          m_axis_tuser
);

    localparam int CWD = sgx_pkg::COORD_W;

    sgx_pkg::coord_t row_f;
    sgx_pkg::coord_t col_f;
    sgx_pkg::grad_t  grad_f;

    assign row_f  = m_axis_tdata[CWD-1:0];
    assign col_f  = m_axis_tdata[2*CWD-1:CWD];
    assign grad_f = m_axis_tdata[2*CWD+sgx_pkg::GRAD_W-1:2*CWD];

    // A stalled beat stays put
    `SGX_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

    // The frame closes on the last beat of its pixel
    `SGX_ASSERT_NOW(a_frame_run, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

    // Final beat of a frame is the right border one row above the bottom
    `SGX_ASSERT_NOW(a_frame_pos, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        col_f == row_f + sgx_pkg::coord_t'(1))

    // Top row and left column carry no gradient
    `SGX_ASSERT_NOW(a_border_zero, clk, rst_n,
        m_axis_tvalid && (row_f == '0 || col_f == '0), grad_f == '0)

endmodule

bind sobel_gradient_x_stream_core sgx_checker u_sgx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== sim/tb_sobel_gradient_x_stream_core.sv =====
`timescale 1ns / 1ps

module tb_sobel_gradient_x_stream_core;

    localparam int SIDE_MAX       = 1024;
    localparam int RANDOM_ITEMS   = 950;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum logic {STEP_PIXEL, STEP_SIDE} step_kind_t;

    typedef struct {
        step_kind_t        kind;
        logic [10:0]       value;
        int                n_typed;
        sgx_pkg::result_t  t0;
        sgx_pkg::result_t  t1;
    } dir_step_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             cfg_we        = 1'b0;
    logic [sgx_pkg::SIDE_W-1:0] cfg_wdata = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;   // pixel
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [31:0]      m_axis_tdata;         // out_row, out_col, gradient
    logic             m_axis_tlast;         // run_last
    logic             m_axis_tuser;         // frame_last

    // Gradient predictor state
    logic [10:0] side_reg;
    logic [7:0]  line_above     [0:SIDE_MAX-1];
    logic [7:0]  line_two_above [0:SIDE_MAX-1];
    logic [7:0]  win            [0:5];
    int          row_pos;
    int          col_pos;

    sgx_pkg::result_t expected_beats [$];
    dir_step_t        directed_steps [$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    sobel_gradient_x_stream_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic sgx_pkg::result_t make_beat(input int row, input int col,
                                                   input int grad,
                                                   input bit rl, input bit fl);
        sgx_pkg::result_t b;
        if (grad > 1023)
            grad = 1023;
        if (grad < -1024)
            grad = -1024;
        b.row        = row[9:0];
        b.col        = col[9:0];
        b.grad       = grad[10:0];
        b.run_last   = rl;
        b.frame_last = fl;
        return b;
    endfunction

    function automatic dir_step_t step_px(input logic [7:0] v);
        dir_step_t s;
        s.kind    = STEP_PIXEL;
        s.value   = {3'b000, v};
        s.n_typed = 0;
        s.t0      = '0;
        s.t1      = '0;
        return s;
    endfunction

    function automatic dir_step_t step_side(input logic [10:0] v);
        dir_step_t s;
        s = step_px(8'h00);
        s.kind  = STEP_SIDE;
        s.value = v;
        return s;
    endfunction

    function automatic dir_step_t step_typed(input logic [7:0] v, input int n,
                                             input sgx_pkg::result_t a,
                                             input sgx_pkg::result_t b);
        dir_step_t s;
        s = step_px(v);
        s.n_typed = n;
        s.t0      = a;
        s.t1      = b;
        return s;
    endfunction

    task automatic clear_model();
        side_reg = sgx_pkg::SIDE_RESET[10:0];
        for (int i = 0; i < SIDE_MAX; i++)
        begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win[i] = '0;
        row_pos = 0;
        col_pos = 0;
    endtask

    // Advance the window model by one pixel and return the beats it releases
    task automatic predict_gradient(input logic [7:0] px, output int cnt,
                                    output sgx_pkg::result_t b0,
                                    output sgx_pkg::result_t b1);
        int               n, r, c, top, mid, grad;
        bit               frame_end;
        sgx_pkg::result_t beats [0:1];
        n = side_reg;
        if (n < 3)
            n = 3;
        if (n > SIDE_MAX)
            n = SIDE_MAX;
        r = row_pos;
        c = col_pos;
        if (r >= n)
            r = 0;
        if (c >= n)
            c = 0;
        top       = line_two_above[c];
        mid       = line_above[c];
        cnt       = 0;
        frame_end = 1'b0;
        beats[0]  = '0;
        beats[1]  = '0;

        if (r == 0)
        begin
            beats[cnt] = make_beat(0, c, 0, 1'b0, 1'b0);
            cnt++;
        end
        else if (r >= 2)
        begin
            if (c == 0)
            begin
                beats[cnt] = make_beat(r - 1, 0, 0, 1'b0, 1'b0);
                cnt++;
            end
            else if (c >= 2)
            begin
                grad = (top + 2 * mid + px) - (win[0] + 2 * win[1] + win[2]);
                beats[cnt] = make_beat(r - 1, c - 1, grad, 1'b0, 1'b0);
                cnt++;
                if (c == n - 1)
                begin
                    beats[cnt] = make_beat(r - 1, n - 1, 0, 1'b0, 1'b0);
                    cnt++;
                end
            end
            // bottom row trails along with the row above it
            if (r == n - 1)
            begin
                if (c == 0)
                begin
                    beats[cnt] = make_beat(r, 0, 0, 1'b0, 1'b0);
                    cnt++;
                end
                else if (c == 1)
                begin
                    beats[0] = make_beat(r, 1, 0, 1'b0, 1'b0);
                    beats[1] = make_beat(r, 2, 0, 1'b0, 1'b0);
                    cnt = 2;
                end
                else if (c <= n - 2)
                begin
                    beats[cnt] = make_beat(r, c + 1, 0, 1'b0, 1'b0);
                    cnt++;
                end
            end
        end

        // shift the window and update the line stores
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top[7:0];
        win[4] = mid[7:0];
        win[5] = px;
        line_two_above[c] = mid[7:0];
        line_above[c]     = px;

        c++;
        if (c >= n)
        begin
            c = 0;
            r++;
            if (r >= n)
            begin
                r = 0;
                frame_end = 1'b1;
            end
        end
        row_pos = r;
        col_pos = c;

        if (cnt > 0)
        begin
            beats[cnt - 1].run_last   = 1'b1;
            beats[cnt - 1].frame_last = frame_end;
        end
        b0 = beats[0];
        b1 = beats[1];
    endtask

    // Offer one pixel beat, hold it until taken, then queue what it releases
    task automatic send_pixel(input logic [7:0] px, input int n_typed,
                              input sgx_pkg::result_t t0, input sgx_pkg::result_t t1);
        int               cnt;
        sgx_pkg::result_t p0, p1;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        predict_gradient(px, cnt, p0, p1);
        if (n_typed > 0)
        begin
            cnt = n_typed;
            p0  = t0;
            p1  = t1;
        end
        if (cnt > 0)
            expected_beats.push_back(p0);
        if (cnt > 1)
            expected_beats.push_back(p1);
    endtask

    // Drain the block, then write the side register (also restarts the frame)
    task automatic write_side(input logic [10:0] v);
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        side_reg = v;
        row_pos  = 0;
        col_pos  = 0;
        cfg_we <= 1'b0;
    endtask

    // Check result beats and drive the receiver's ready
    always @(posedge clk)
    begin : result_side
        sgx_pkg::result_t got, want;
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            got.row        = m_axis_tdata[9:0];
            got.col        = m_axis_tdata[19:10];
            got.grad       = m_axis_tdata[30:20];
            got.run_last   = m_axis_tlast;
            got.frame_last = m_axis_tuser;
            if (expected_beats.size() == 0)
                report_mismatch($sformatf("unexpected beat row %0d col %0d",
                                          got.row, got.col));
            else
            begin
                want = expected_beats.pop_front();
                if (got.row !== want.row)
                    report_mismatch($sformatf("row got %0d exp %0d", got.row, want.row));
                if (got.col !== want.col)
                    report_mismatch($sformatf("col got %0d exp %0d (row %0d)",
                                              got.col, want.col, want.row));
                if (got.grad !== want.grad)
                    report_mismatch($sformatf("gradient got %0d exp %0d at (%0d,%0d)",
                                              $signed(got.grad), $signed(want.grad),
                                              want.row, want.col));
                if (got.run_last !== want.run_last)
                    report_mismatch($sformatf("tlast got %b exp %b at (%0d,%0d)",
                                              got.run_last, want.run_last,
                                              want.row, want.col));
                if (got.frame_last !== want.frame_last)
                    report_mismatch($sformatf("tuser got %b exp %b at (%0d,%0d)",
                                              got.frame_last, want.frame_last,
                                              want.row, want.col));
            end
        end

        // hold off for a long stretch when asked, else stall at random
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        dir_step_t st;
        int        random_sent;
        int        pick;
        int        side;
        int        count;
        int        pick_px;
        logic [7:0] px;

        clear_model();
        random_sent   = 0;
        send_idle_pct = 26;
        recv_idle_pct = 75;

        // after reset the side is 512: row zero comes straight back as zeros
        directed_steps.push_back(step_typed(8'h00, 1,
                                            make_beat(0, 0, 0, 1'b1, 1'b0), '0));
        directed_steps.push_back(step_typed(8'hFF, 1,
                                            make_beat(0, 1, 0, 1'b1, 1'b0), '0));
        // smallest image, strongest negative edge
        directed_steps.push_back(step_side(11'd3));
        for (int i = 0; i < 8; i++)
            directed_steps.push_back(step_px((i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h80 : 8'h00));
        directed_steps.push_back(step_typed(8'h00, 2, make_beat(1, 1, -1020, 1'b0, 1'b0),
                                            make_beat(1, 2, 0, 1'b1, 1'b1)));
        // next frame without a write: strongest positive edge
        for (int i = 0; i < 8; i++)
            directed_steps.push_back(step_px((i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'h80 : 8'hFF));
        directed_steps.push_back(step_typed(8'hFF, 2, make_beat(1, 1, 1020, 1'b0, 1'b0),
                                            make_beat(1, 2, 0, 1'b1, 1'b1)));
        // side values outside the range and the largest legal side
        directed_steps.push_back(step_side(11'd0));
        directed_steps.push_back(step_typed(8'h5A, 1,
                                            make_beat(0, 0, 0, 1'b1, 1'b0), '0));
        directed_steps.push_back(step_side(11'd2047));
        directed_steps.push_back(step_typed(8'hA5, 1,
                                            make_beat(0, 0, 0, 1'b1, 1'b0), '0));
        directed_steps.push_back(step_side(11'd1024));
        directed_steps.push_back(step_typed(8'h01, 1,
                                            make_beat(0, 0, 0, 1'b1, 1'b0), '0));

        // release reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (directed_steps[i])
        begin
            st = directed_steps[i];
            if (st.kind == STEP_SIDE)
                write_side(st.value);
            else
                send_pixel(st.value[7:0], st.n_typed, st.t0, st.t1);
        end

        // random frames: mostly complete small images, some cut short or odd sides
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       side = 0;
                    1:       side = $urandom_range(1, 2);
                    2:       side = 1024;
                    3:       side = 2047;
                    default: side = $urandom_range(1025, 2046);
                endcase
                count = $urandom_range(3, 40);
            end
            else
            begin
                side = $urandom_range(3, 14);
                if (pick == 1)
                    count = $urandom_range(1, side * side - 1);
                else
                    count = side * side * $urandom_range(1, 2);
            end
            write_side(side[10:0]);
            repeat (count)
            begin
                if (random_sent < RANDOM_ITEMS / 3)
                begin
                    send_idle_pct = 26;
                    recv_idle_pct = 75;
                end
                else if (random_sent < 2 * RANDOM_ITEMS / 3)
                begin
                    send_idle_pct = 75;
                    recv_idle_pct = 26;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    if (hold_requests == 0)
                        hold_requests = 1;
                end
                pick_px = $urandom_range(0, 9);
                if (pick_px == 0)
                    px = 8'h00;
                else if (pick_px == 1)
                    px = 8'hFF;
                else
                    px = 8'($urandom_range(0, 255));
                send_pixel(px, 0, '0, '0);
                random_sent++;
            end
        end

        // drain and let the pipeline settle
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
